### rtl/gpcd_pkg.sv
// Shared types and constants for the gradient predict / color decode block.
// Used by every module under rtl/ except gpcd_ram; depends on nothing.
`default_nettype none

package gpcd_pkg;

	// Field and register widths
	localparam int PLANE_W  = 8;
	localparam int PIXEL_W  = 3 * PLANE_W;
	localparam int WIDTH_W  = 13;
	localparam int HEIGHT_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Defaults
	localparam int MAX_WIDTH_DEF = 4096;
	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;

	// Reconstruction offset added to every predicted (non-bypass) byte
	localparam logic [PLANE_W-1:0] REC_OFFSET = 8'h80;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// Per-pixel control carried down the pipeline
	typedef struct packed {
		logic bypass;     // first row or first column: codes pass unchanged
		logic frame_end;  // last pixel of the frame
	} pix_ctl_t;

endpackage

`default_nettype wire

### rtl/gpcd_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// Standalone; no package dependency.
`default_nettype none

module gpcd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/gpcd_lane.sv
// One plane lane: gradient predictor and byte reconstruction.
// Depends on gpcd_pkg.
`default_nettype none

module gpcd_lane (
	input  wire logic [gpcd_pkg::PLANE_W-1:0] code,
	input  wire logic [gpcd_pkg::PLANE_W-1:0] up,
	input  wire logic [gpcd_pkg::PLANE_W-1:0] left,
	input  wire logic [gpcd_pkg::PLANE_W-1:0] upleft,
	input  wire logic                         bypass,
	output      logic [gpcd_pkg::PLANE_W-1:0] rec
);

	logic signed [9:0]  du, dl;
	logic signed [10:0] dsum;
	logic [9:0]         d_abs, du_abs, dl_abs;
	logic [gpcd_pkg::PLANE_W-1:0] pred;

	// Differences against the up-left neighbor
	always_comb begin
		du   = $signed({2'b00, up})   - $signed({2'b00, upleft});
		dl   = $signed({2'b00, left}) - $signed({2'b00, upleft});
		dsum = 11'(du) + 11'(dl);
		du_abs = du[9]   ? 10'(-du)   : 10'(du);
		dl_abs = dl[9]   ? 10'(-dl)   : 10'(dl);
		d_abs  = dsum[10] ? 10'(-dsum) : dsum[9:0];
	end

	// Gradient selection
	always_comb begin
		if (d_abs >= du_abs && dl_abs >= du_abs) begin
			pred = left;
		end else if (d_abs < dl_abs) begin
			pred = upleft;
		end else begin
			pred = up;
		end
	end

	assign rec = bypass ? code : (code + pred + gpcd_pkg::REC_OFFSET);

endmodule

`default_nettype wire

### rtl/gpcd_color.sv
// Merge stage: reversible color transform over the three reconstructed planes.
// Depends on gpcd_pkg.
`default_nettype none

module gpcd_color (
	input  wire logic [gpcd_pkg::PIXEL_W-1:0] rec,
	output      logic [gpcd_pkg::PIXEL_W-1:0] pix   // first, second, third from bit 0
);

	logic [7:0]        p0, p1, p2, q, g;
	logic signed [8:0] sum;
	logic signed [8:0] sum_q4;

	// r and b as offset bytes, g = p0 - floor((r + b) / 4)
	always_comb begin
		p0     = rec[7:0];
		p1     = rec[15:8]  ^ gpcd_pkg::REC_OFFSET;
		p2     = rec[23:16] ^ gpcd_pkg::REC_OFFSET;
		sum    = 9'($signed(p1)) + 9'($signed(p2));
		sum_q4 = sum >>> 2;
		q      = sum_q4[7:0];
		g      = p0 - q;
		pix    = {p2 + g, g, p1 + g};
	end

endmodule

`default_nettype wire

### rtl/gradient_predict_color_decode.sv
// Top level of the gradient predict / color decode block.
// Depends on gpcd_pkg, gpcd_ram, gpcd_lane and gpcd_color.
//
// Usage:
//   s_axis carries one pixel per transaction in raster order, three coded
//   plane bytes in tdata (plane 0 in the low byte). m_axis returns one
//   pixel per transaction: three decoded bytes in tdata and tlast high on
//   the last pixel of the frame.
//   cfg_* writes image_width (index 0) and image_height (index 1); writes
//   are taken every cycle and must only be issued while the block is idle.
//   Throughput is one pixel per cycle while m_axis_tready stays high. Between
//   input and the earliest output transaction lie three register stages:
//   input stage with line-buffer read, lane reconstruction register,
//   color-transform output register. The rate is set by the left-neighbor
//   loop, which closes through the three plane lanes, and by the one
//   line-buffer read port, read once per pixel.
//   Reset clears counters, neighbors and valid flags and sets the config
//   registers to defaults (width 640, height 480); no clearing pass over
//   the line buffer is needed. When the receiver stalls, tready backs up
//   through the stages and input stalls after the three stages fill.
`default_nettype none

module gradient_predict_color_decode #(
	parameter int MAX_WIDTH = gpcd_pkg::MAX_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// config channel
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [gpcd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gpcd_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input pixels
	input  wire logic                               s_axis_tvalid,
	output      logic                               s_axis_tready,
	input  wire logic [gpcd_pkg::PIXEL_W-1:0]       s_axis_tdata,  // code_plane0, code_plane1, code_plane2
	// output pixels
	output      logic                               m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output      logic [gpcd_pkg::PIXEL_W-1:0]       m_axis_tdata,  // out_first, out_second, out_third
	output      logic                               m_axis_tlast   // frame_end
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > gpcd_pkg::WIDTH_W) ? CW + 1 : gpcd_pkg::WIDTH_W;
	localparam int PW = gpcd_pkg::PLANE_W;
	localparam int HW = gpcd_pkg::HEIGHT_W;

	logic [gpcd_pkg::WIDTH_W-1:0] width_q;
	logic [HW-1:0]                height_q;
	logic [CW-1:0]                col_q;
	logic [HW-1:0]                row_q;

	logic [EW-1:0] w_eff, col_inc;
	logic [HW-1:0] h_eff;
	logic [HW:0]   row_inc;
	logic          last_col, last_row;

	logic          in_acc, s1_adv, s2_adv, out_adv;
	logic          s1_valid_q, s2_valid_q, out_valid_q;
	logic          s1_free, s2_free, out_free;

	gpcd_pkg::pix_ctl_t        ctl_in, ctl_s1;
	logic                      frame_end_s2;
	logic [CW-1:0]             col_s1;
	logic [gpcd_pkg::PIXEL_W-1:0] code_s1, up_s1, rec, rec_s2, pix;
	logic [gpcd_pkg::PIXEL_W-1:0] left_q, upleft_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gpcd_pkg::WIDTH_RST;
			height_q <= gpcd_pkg::HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				gpcd_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[gpcd_pkg::WIDTH_W-1:0];
				gpcd_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[HW-1:0];
				default: ;
			endcase
		end
	end

	// Handshake chain
	always_comb begin
		out_free = !out_valid_q || m_axis_tready;
		s2_free  = !s2_valid_q || out_free;
		s1_free  = !s1_valid_q || s2_free;
		s_axis_tready = s1_free;
		in_acc  = s_axis_tvalid && s1_free;
		s1_adv  = s1_valid_q && s2_free;
		s2_adv  = s2_valid_q && out_free;
		out_adv = out_valid_q && m_axis_tready;
	end

	// Raster position and end-of-row / end-of-frame detection
	always_comb begin
		if (width_q == '0) begin
			w_eff = EW'(1);
		end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(width_q);
		end
		h_eff    = (height_q == '0) ? HW'(1) : height_q;
		col_inc  = EW'(col_q) + EW'(1);
		row_inc  = {1'b0, row_q} + (HW+1)'(1);
		last_col = col_inc >= w_eff;
		last_row = row_inc >= {1'b0, h_eff};
		ctl_in.bypass    = (row_q == '0) || (col_q == '0);
		ctl_in.frame_end = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_inc[HW-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// Line buffer: read at accept, written when the pixel leaves stage 1
	gpcd_ram #(
		.WIDTH (gpcd_pkg::PIXEL_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (rec),
		.re    (in_acc),
		.raddr (col_q),
		.rdata (up_s1)
	);

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_free) begin
			s1_valid_q <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			code_s1 <= s_axis_tdata;
			col_s1  <= col_q;
			ctl_s1  <= ctl_in;
		end
	end

	// Three plane lanes
	for (genvar i = 0; i < 3; i++) begin : g_lane
		gpcd_lane u_lane (
			.code   (code_s1[i*PW +: PW]),
			.up     (up_s1[i*PW +: PW]),
			.left   (left_q[i*PW +: PW]),
			.upleft (upleft_q[i*PW +: PW]),
			.bypass (ctl_s1.bypass),
			.rec    (rec[i*PW +: PW])
		);
	end

	// Neighbor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			upleft_q <= '0;
		end else if (s1_adv) begin
			left_q   <= rec;
			upleft_q <= up_s1;
		end
	end

	// Stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_free) begin
			s2_valid_q <= s1_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rec_s2       <= rec;
			frame_end_s2 <= ctl_s1.frame_end;
		end
	end

	// Merge stage: color transform
	gpcd_color u_color (
		.rec (rec_s2),
		.pix (pix)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_adv) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			m_axis_tdata <= pix;
			m_axis_tlast <= frame_end_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;

endmodule

`default_nettype wire
